/* hdl/hpt_pkg.sv */
// Shared constants, types and helpers for the homogeneous point transform core.
`timescale 1ns / 1ps
`default_nettype none
package hpt_pkg;
   localparam int FracBits = 16;
   localparam int WordWidth = 32;
   localparam int DotWidth = 2 * WordWidth + 3;        // exact sum of four products
   localparam int NumWidth = DotWidth + FracBits;      // scaled dividend width
   localparam int QuoWidth = NumWidth;                 // quotient width
   localparam int NumCells = QuoWidth;                 // one quotient bit per cell
   localparam int ReqDataWidth = 232;                  // 227 bits padded to bytes
   localparam int RspDataWidth = 104;                  // 98 bits padded to bytes

   localparam logic ActLoad = 1'b0;
   localparam logic ActXform = 1'b1;

   localparam logic signed [WordWidth-1:0] SatMax = {1'b0, {(WordWidth-1){1'b1}}};
   localparam logic signed [WordWidth-1:0] SatMin = {1'b1, {(WordWidth-1){1'b0}}};
   localparam logic signed [WordWidth-1:0] FixOne =
      WordWidth'(64'sd1 <<< FracBits);

   // One coordinate in flight through the divider cells.
   typedef struct packed {
      logic [NumWidth-1:0] rem;   // partial remainder
      logic [NumWidth-1:0] num;   // dividend bits still to shift in
      logic [QuoWidth-1:0] quo;   // quotient so far
   } div_lane_type;

   // Per-item control riding beside the lanes.
   typedef struct packed {
      logic                valid;
      logic                zero_w;
      logic                unit_w;
      logic [2:0]          neg;
      logic [NumWidth-1:0] den;
      logic [DotWidth-1:0] raw_x;
      logic [DotWidth-1:0] raw_y;
      logic [DotWidth-1:0] raw_z;
   } div_ctl_type;

   typedef struct packed {
      div_ctl_type      ctl;
      div_lane_type [2:0] lane;
   } div_beat_type;
endpackage
`default_nettype wire

/* hdl/hpt_dot_row.sv */
// One row dot product: four products registered, then summed and floored.
`timescale 1ns / 1ps
`default_nettype none
module hpt_dot_row (
   input  wire logic                                 clock,
   input  wire logic                                 advance,
   input  wire logic signed [hpt_pkg::WordWidth-1:0] coef_0,
   input  wire logic signed [hpt_pkg::WordWidth-1:0] coef_1,
   input  wire logic signed [hpt_pkg::WordWidth-1:0] coef_2,
   input  wire logic signed [hpt_pkg::WordWidth-1:0] coef_3,
   input  wire logic signed [hpt_pkg::WordWidth-1:0] px,
   input  wire logic signed [hpt_pkg::WordWidth-1:0] py,
   input  wire logic signed [hpt_pkg::WordWidth-1:0] pz,
   output logic signed [hpt_pkg::DotWidth-1:0]       dot
);
   localparam int PW = 2 * hpt_pkg::WordWidth;
   logic signed [PW-1:0] p0_ff, p1_ff, p2_ff, p3_ff;
   logic signed [hpt_pkg::DotWidth-1:0] sum;

   always_ff @(posedge clock) begin
      if (advance) begin
         p0_ff <= px * coef_0;
         p1_ff <= py * coef_1;
         p2_ff <= pz * coef_2;
         p3_ff <= PW'(coef_3) <<< hpt_pkg::FracBits;
      end
   end

   // exact sum; arithmetic shift floors toward minus infinity
   assign sum = hpt_pkg::DotWidth'(p0_ff) + hpt_pkg::DotWidth'(p1_ff)
              + hpt_pkg::DotWidth'(p2_ff) + hpt_pkg::DotWidth'(p3_ff);
   always_ff @(posedge clock) begin
      if (advance) begin
         dot <= sum >>> hpt_pkg::FracBits;
      end
   end
endmodule
`default_nettype wire

/* hdl/hpt_div_cell.sv */
// One restoring-division cell: retires one quotient bit for three lanes.
`timescale 1ns / 1ps
`default_nettype none
module hpt_div_cell (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  advance,
   input  wire hpt_pkg::div_beat_type beat_in,
   output hpt_pkg::div_beat_type      beat_out
);
   hpt_pkg::div_beat_type beat_ff, beat_in_c;
   logic [hpt_pkg::NumWidth-1:0] trial;

   always_comb begin
      beat_in_c = beat_in;
      trial = '0;
      for (int l = 0; l < 3; l++) begin
         trial = {beat_in.lane[l].rem[hpt_pkg::NumWidth-2:0],
                  beat_in.lane[l].num[hpt_pkg::NumWidth-1]};
         beat_in_c.lane[l].num = beat_in.lane[l].num << 1;
         if (trial >= beat_in.ctl.den) begin
            beat_in_c.lane[l].rem = trial - beat_in.ctl.den;
            beat_in_c.lane[l].quo = {beat_in.lane[l].quo[hpt_pkg::QuoWidth-2:0], 1'b1};
         end else begin
            beat_in_c.lane[l].rem = trial;
            beat_in_c.lane[l].quo = {beat_in.lane[l].quo[hpt_pkg::QuoWidth-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff.ctl.valid <= 1'b0;
      end else if (advance) begin
         beat_ff <= beat_in_c;
      end
   end
   assign beat_out = beat_ff;
endmodule
`default_nettype wire

/* hdl/homogeneous_point_transform_core.sv */
// Top level of the homogeneous 4x4 point transform with perspective divide.
// Usage:
//   req_ channel: one beat either loads a matrix row (action 0) or
//   transforms a point (action 1). Loads give no response beat.
//   rsp_ channel: one beat per transform with x, y, z and two flags.
// Timing: one beat per cycle sustained while rsp_tready is high. A transform passes
//   the input registers, the product and sum registers, a prepare register,
//   the chain of NumCells divider cells (one quotient bit per cell, 83 at
//   Q16.16) and the saturating output register.
// The whole pipe advances together; when rsp_tready is low with a
//   response held, the pipe freezes and req_tready drops, so no beat is lost.
// A load updates the matrix at acceptance; later transforms see it, earlier
//   ones have already captured their products.
// Reset: the matrix returns to identity and all valid bits clear.
`timescale 1ns / 1ps
`default_nettype none
module homogeneous_point_transform_core (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // fields from bit 0: action, row_index, coef_col0..3, point_x, y, z
   input  wire logic [hpt_pkg::ReqDataWidth-1:0] req_tdata,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // fields from bit 0: out_x, out_y, out_z, zero_w_error, overflow
   output logic [hpt_pkg::RspDataWidth-1:0]       rsp_tdata
);
   localparam int W = hpt_pkg::WordWidth;
   localparam int D = hpt_pkg::DotWidth;
   localparam int N = hpt_pkg::NumWidth;
   localparam int C = hpt_pkg::NumCells;

   logic advance;
   logic [W-1:0] mat_ff [16];
   logic act;
   logic [1:0] row;
   logic signed [W-1:0] cf [4];
   logic signed [W-1:0] pt [3];

   assign act = req_tdata[0];
   assign row = req_tdata[2:1];
   always_comb begin
      for (int i = 0; i < 4; i++) cf[i] = req_tdata[3 + i*W +: W];
      for (int i = 0; i < 3; i++) pt[i] = req_tdata[3 + 4*W + i*W +: W];
   end

   // pipe moves whenever the output register is free or being drained
   assign advance = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 16; i++)
            mat_ff[i] <= (i % 5 == 0) ? hpt_pkg::FixOne : '0;
      end else if (req_tvalid && req_tready && act == hpt_pkg::ActLoad) begin
         for (int i = 0; i < 4; i++) mat_ff[{row, 2'(i)}] <= cf[i];
      end
   end

   // hold the point and matrix in input registers
   logic signed [W-1:0] pt_ff [3];
   logic signed [W-1:0] m_ff [16];
   logic v0_ff, v1_ff, v2_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0; v1_ff <= 1'b0; v2_ff <= 1'b0;
      end else if (advance) begin
         for (int i = 0; i < 3; i++) pt_ff[i] <= pt[i];
         for (int i = 0; i < 16; i++) m_ff[i] <= mat_ff[i];
         v0_ff <= req_tvalid && act == hpt_pkg::ActXform;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
      end
   end

   logic signed [D-1:0] dots [4];

   // products then sums, both stages frozen with the rest of the pipe
   // (v1/v2 track them)
   for (genvar r = 0; r < 4; r++) begin : g_row
      logic signed [D-1:0] dot_r;
      hpt_dot_row u_row (
         .clock (clock), .advance (advance),
         .coef_0 (m_ff[r*4+0]), .coef_1 (m_ff[r*4+1]),
         .coef_2 (m_ff[r*4+2]), .coef_3 (m_ff[r*4+3]),
         .px (pt_ff[0]), .py (pt_ff[1]), .pz (pt_ff[2]),
         .dot (dot_r)
      );
      assign dots[r] = dot_r;
   end

   // prepare: sign handling and dividend scaling
   hpt_pkg::div_beat_type prep, chain [C+1];
   logic signed [D-1:0] wc;
   assign wc = dots[3];
   always_comb begin
      prep = '0;
      prep.ctl.valid = v2_ff;
      prep.ctl.zero_w = (wc == '0);
      prep.ctl.unit_w = (wc == D'(hpt_pkg::FixOne));
      prep.ctl.den = N'(wc[D-1] ? -wc : wc);
      prep.ctl.raw_x = dots[0];
      prep.ctl.raw_y = dots[1];
      prep.ctl.raw_z = dots[2];
      for (int l = 0; l < 3; l++) begin
         prep.ctl.neg[l] = dots[l][D-1] ^ wc[D-1];
         prep.lane[l].num = N'(dots[l][D-1] ? -dots[l] : dots[l]) << hpt_pkg::FracBits;
      end
      if (prep.ctl.zero_w) prep.ctl.den = N'(1);
   end

   hpt_pkg::div_beat_type prep_ff;
   always_ff @(posedge clock) begin
      if (reset) prep_ff.ctl.valid <= 1'b0;
      else if (advance) prep_ff <= prep;
   end
   assign chain[0] = prep_ff;

   for (genvar c = 0; c < C; c++) begin : g_cell
      hpt_div_cell u_cell (
         .clock (clock), .reset (reset), .advance (advance),
         .beat_in (chain[c]), .beat_out (chain[c+1])
      );
   end

   // saturate into the output register
   hpt_pkg::div_beat_type fin;
   logic [W-1:0] res [3];
   logic ovf;
   logic signed [D-1:0] raw [3];
   logic [hpt_pkg::QuoWidth-1:0] lim;
   assign fin = chain[C];
   assign lim = hpt_pkg::QuoWidth'(1) << (W - 1);
   always_comb begin
      raw[0] = fin.ctl.raw_x; raw[1] = fin.ctl.raw_y; raw[2] = fin.ctl.raw_z;
      ovf = 1'b0;
      for (int l = 0; l < 3; l++) begin
         res[l] = '0;
         if (fin.ctl.zero_w) begin
            res[l] = '0;
         end else if (fin.ctl.unit_w) begin
            if (raw[l] > D'(hpt_pkg::SatMax)) begin res[l] = hpt_pkg::SatMax; ovf = 1'b1; end
            else if (raw[l] < D'(hpt_pkg::SatMin)) begin res[l] = hpt_pkg::SatMin; ovf = 1'b1; end
            else res[l] = W'(raw[l]);
         end else if (fin.ctl.neg[l]) begin
            if (fin.lane[l].quo > lim) begin res[l] = hpt_pkg::SatMin; ovf = 1'b1; end
            else res[l] = W'(-fin.lane[l].quo);
         end else begin
            if (fin.lane[l].quo > lim - 1) begin res[l] = hpt_pkg::SatMax; ovf = 1'b1; end
            else res[l] = W'(fin.lane[l].quo);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid <= 1'b0;
      end else if (advance) begin
         rsp_tvalid <= fin.ctl.valid;
         rsp_tdata <= {6'b0, ovf, fin.ctl.zero_w, res[2], res[1], res[0]};
      end
   end
endmodule
`default_nettype wire
